// ===== hdl/ttlp_pkg.sv =====
// Shared types and constants for the touch tap / long-press classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package ttlp_pkg;

  // Default coordinate width
  localparam int COORD_BITS_DEF = 10;

  // Configuration register reset values
  localparam logic [9:0]  SCREEN_W_RST  = 10'd240;
  localparam logic [9:0]  HOT_W_RST     = 10'd48;
  localparam logic [9:0]  HOT_H_RST     = 10'd53;
  localparam logic [15:0] LONG_MS_RST   = 16'd850;
  localparam logic [15:0] TAP_MAX_RST   = 16'd600;
  localparam logic [15:0] TAP_GAP_RST   = 16'd250;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  // Register indexes on the configuration channel
  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_HOT_WIDTH     = 3'd1,
    REG_HOT_HEIGHT    = 3'd2,
    REG_LONG_PRESS_MS = 3'd3,
    REG_TAP_MAX_MS    = 3'd4,
    REG_TAP_GAP_MS    = 3'd5
  } reg_idx_t;

  // Gesture codes
  localparam logic [1:0] GEST_NONE = 2'd0;
  localparam logic [1:0] GEST_LONG = 2'd1;
  localparam logic [1:0] GEST_TAP  = 2'd2;

  // Tap region codes
  localparam logic [1:0] REGION_OTHER = 2'd0;
  localparam logic [1:0] REGION_LEFT  = 2'd1;
  localparam logic [1:0] REGION_RIGHT = 2'd2;

  // Configuration values as seen by the classifier
  typedef struct packed {
    logic [9:0]  screen_width;
    logic [9:0]  hot_width;
    logic [9:0]  hot_height;
    logic [15:0] long_press_ms;
    logic [15:0] tap_max_ms;
    logic [15:0] tap_gap_ms;
  } cfg_t;

  // Classification result without coordinates
  typedef struct packed {
    logic [1:0] gesture;
    logic [1:0] region;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/ttlp_cfg.sv =====
// Configuration register file for the touch classifier.
// Depends on ttlp_pkg (register indexes, reset values, cfg_t).
`default_nettype none

module ttlp_cfg
  import ttlp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                          cfg
);

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  // Decode one write transfer; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_SCREEN_WIDTH:  cfg_nxt.screen_width  = cfg_data[9:0];
        REG_HOT_WIDTH:     cfg_nxt.hot_width     = cfg_data[9:0];
        REG_HOT_HEIGHT:    cfg_nxt.hot_height    = cfg_data[9:0];
        REG_LONG_PRESS_MS: cfg_nxt.long_press_ms = cfg_data;
        REG_TAP_MAX_MS:    cfg_nxt.tap_max_ms    = cfg_data;
        REG_TAP_GAP_MS:    cfg_nxt.tap_gap_ms    = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= SCREEN_W_RST;
      cfg_r.hot_width     <= HOT_W_RST;
      cfg_r.hot_height    <= HOT_H_RST;
      cfg_r.long_press_ms <= LONG_MS_RST;
      cfg_r.tap_max_ms    <= TAP_MAX_RST;
      cfg_r.tap_gap_ms    <= TAP_GAP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ttlp_core.sv =====
// Gesture state and classification: one sample per step.
// Depends on ttlp_pkg (cfg_t, res_t, gesture and region codes).
`default_nettype none

module ttlp_core
  import ttlp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire cfg_t                  cfg,
  input  wire logic                  pen_down,
  input  wire logic [COORD_BITS-1:0] touch_x,
  input  wire logic [COORD_BITS-1:0] touch_y,
  input  wire logic [31:0]           time_ms,
  output res_t                       res,
  output logic      [COORD_BITS-1:0] gesture_x,
  output logic      [COORD_BITS-1:0] gesture_y
);

  // Width for signed hotspot compares
  localparam int CW = ((COORD_BITS > 10) ? COORD_BITS : 10) + 2;

  logic                  was_down_r, was_down_nxt;
  logic                  long_fired_r, long_fired_nxt;
  logic [31:0]           press_start_r, press_start_nxt;
  logic [31:0]           last_gest_r, last_gest_nxt;
  logic [COORD_BITS-1:0] last_x_r, last_x_nxt;
  logic [COORD_BITS-1:0] last_y_r, last_y_nxt;

  logic                  press_rise;
  logic [31:0]           hold_diff;
  logic [31:0]           gap_diff;
  logic                  long_hit;
  logic                  tap_hit;
  logic signed [CW-1:0]  rgt_bound;
  logic signed [CW-1:0]  x_s;
  logic [CW-1:0]         x_u, y_u, hw_u, hh_u;
  logic [1:0]            region;

  assign press_rise = pen_down && !was_down_r;
  // A new press restarts the hold timer at zero
  assign hold_diff  = press_rise ? 32'd0 : (time_ms - press_start_r);
  assign gap_diff   = time_ms - last_gest_r;

  assign long_hit = pen_down && (press_rise || !long_fired_r) &&
                    (hold_diff > {16'd0, cfg.long_press_ms});
  assign tap_hit  = !pen_down && was_down_r && !long_fired_r &&
                    (hold_diff < {16'd0, cfg.tap_max_ms}) &&
                    (gap_diff > {16'd0, cfg.tap_gap_ms});

  // Hotspot region of the last down point; right bound may go negative
  assign x_u  = CW'(last_x_r);
  assign y_u  = CW'(last_y_r);
  assign hw_u = CW'(cfg.hot_width);
  assign hh_u = CW'(cfg.hot_height);
  assign x_s  = $signed(x_u);
  assign rgt_bound = $signed(CW'(cfg.screen_width)) - $signed(hw_u);

  always_comb begin
    region = REGION_OTHER;
    if (y_u < hh_u) begin
      priority if (x_u < hw_u) region = REGION_LEFT;
      else if (x_s > rgt_bound) region = REGION_RIGHT;
      else region = REGION_OTHER;
    end
  end

  // Next state
  always_comb begin
    was_down_nxt    = pen_down;
    long_fired_nxt  = press_rise ? 1'b0 : long_fired_r;
    press_start_nxt = press_rise ? time_ms : press_start_r;
    last_gest_nxt   = last_gest_r;
    last_x_nxt      = pen_down ? touch_x : last_x_r;
    last_y_nxt      = pen_down ? touch_y : last_y_r;
    if (long_hit) begin
      long_fired_nxt = 1'b1;
      last_gest_nxt  = time_ms;
    end
    if (tap_hit) begin
      last_gest_nxt = time_ms;
    end
  end

  // Result of this sample
  always_comb begin
    res.gesture = GEST_NONE;
    res.region  = REGION_OTHER;
    gesture_x   = '0;
    gesture_y   = '0;
    if (long_hit) begin
      res.gesture = GEST_LONG;
      gesture_x   = last_x_nxt;
      gesture_y   = last_y_nxt;
    end else if (tap_hit) begin
      res.gesture = GEST_TAP;
      res.region  = region;
      gesture_x   = last_x_r;
      gesture_y   = last_y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_down_r    <= 1'b0;
      long_fired_r  <= 1'b0;
      press_start_r <= '0;
      last_gest_r   <= '0;
      last_x_r      <= '0;
      last_y_r      <= '0;
    end else if (step) begin
      was_down_r    <= was_down_nxt;
      long_fired_r  <= long_fired_nxt;
      press_start_r <= press_start_nxt;
      last_gest_r   <= last_gest_nxt;
      last_x_r      <= last_x_nxt;
      last_y_r      <= last_y_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // A reported long press arms the fired flag
  a_long_arms: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.gesture == GEST_LONG |=> long_fired_r)
    else $error("long press did not set fired flag");

  // Two consecutive samples never both report a long press
  a_long_once: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.gesture == GEST_LONG |=> !(step && res.gesture == GEST_LONG))
    else $error("long press reported twice in a row");

  // Any gesture stamps the gesture time with the sample time
  a_gest_time: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.gesture != GEST_NONE |=> last_gest_r == $past(time_ms))
    else $error("gesture time not updated");

  // A tap ends a press: the next state is pen up
  a_tap_up: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.gesture == GEST_TAP |=> !was_down_r && !long_fired_r)
    else $error("tap left pen state inconsistent");
`endif

endmodule

`default_nettype wire

// ===== hdl/touch_tap_long_press_classifier.sv =====
// Touch tap / long-press classifier, top level.
//
// in_*  : one touch sample per transfer. in_tuser = pen_down.
//         in_tdata = touch_x, touch_y, time_ms (lowest bits first).
// out_* : one result per sample. out_tuser = gesture (0 none, 1 long, 2 tap).
//         out_tdata = tap_region, gesture_x, gesture_y (lowest bits first).
// cfg_* : register writes, index in cfg_addr, value in cfg_data; always ready.
//
// A sample passes the input register, then the classifier compare/update that
// feeds the result register, whose valid flag drives out_tvalid. Throughput
// is one sample per cycle unless the receiver stalls; the gesture state
// registers update in the cycle a sample leaves the input register, so the
// next sample sees them. When the receiver stalls, the result register holds
// and the input register still takes one more sample; in_tready drops only
// when both are full. Synchronous reset (rst_n low) empties both registers,
// clears the gesture state and loads the register defaults (240, 48, 53,
// 850, 600, 250). Depends on ttlp_pkg, ttlp_cfg and ttlp_core.
`default_nettype none

module touch_tap_long_press_classifier
  import ttlp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_FW  = 2 * COORD_BITS + 32,
  localparam int IN_W   = ((IN_FW + 7) / 8) * 8,
  localparam int OUT_FW = 2 + 2 * COORD_BITS,
  localparam int OUT_W  = ((OUT_FW + 7) / 8) * 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // sample channel
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [IN_W-1:0]          in_tdata,   // touch_x, touch_y, time_ms, zero fill
  input  wire logic                     in_tuser,   // pen_down
  // result channel
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic      [OUT_W-1:0]         out_tdata,  // tap_region, gesture_x, gesture_y, zero fill
  output logic      [1:0]               out_tuser,  // gesture
  // configuration channel
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t                  cfg;
  res_t                  res;
  logic [COORD_BITS-1:0] res_x, res_y;

  logic                  s1_vld_r, s1_vld_nxt;
  logic                  s1_pen_r;
  logic [COORD_BITS-1:0] s1_x_r, s1_y_r;
  logic [31:0]           s1_time_r;

  logic                  out_vld_r, out_vld_nxt;
  res_t                  out_res_r;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;

  logic                  adv;
  logic                  step;
  logic                  in_xfer;

  ttlp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ttlp_core #(.COORD_BITS(COORD_BITS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .cfg       (cfg),
    .pen_down  (s1_pen_r),
    .touch_x   (s1_x_r),
    .touch_y   (s1_y_r),
    .time_ms   (s1_time_r),
    .res       (res),
    .gesture_x (res_x),
    .gesture_y (res_y)
  );

  // Handshake: result register frees when empty or taken
  assign adv       = !out_vld_r || out_tready;
  assign step      = s1_vld_r && adv;
  assign in_tready = !s1_vld_r || adv;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_xfer) s1_vld_nxt = 1'b1;
    else if (step) s1_vld_nxt = 1'b0;
    out_vld_nxt = out_vld_r;
    if (step) out_vld_nxt = 1'b1;
    else if (out_tready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pen_r  <= in_tuser;
      s1_x_r    <= in_tdata[COORD_BITS-1:0];
      s1_y_r    <= in_tdata[2*COORD_BITS-1:COORD_BITS];
      s1_time_r <= in_tdata[2*COORD_BITS+31:2*COORD_BITS];
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
      out_x_r   <= res_x;
      out_y_r   <= res_y;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.gesture;

  always_comb begin
    out_tdata = '0;
    out_tdata[1:0] = out_res_r.region;
    out_tdata[COORD_BITS+1:2] = out_x_r;
    out_tdata[2*COORD_BITS+1:COORD_BITS+2] = out_y_r;
  end

endmodule

`default_nettype wire

// ===== verif/touch_tap_long_press_classifier_tb.sv =====
// Self-checking testbench for the touch tap / long-press classifier.
// Drives touch samples and register writes, predicts every gesture result in-line.
// Depends on ttlp_pkg and the touch_tap_long_press_classifier RTL.
`timescale 1ns / 1ps

module touch_tap_long_press_classifier_tb;
  import ttlp_pkg::*;

  localparam int COORD_W = COORD_BITS_DEF;
  localparam int IN_W    = ((2 * COORD_W + 32 + 7) / 8) * 8;
  localparam int OUT_W   = ((2 + 2 * COORD_W + 7) / 8) * 8;
  localparam int PHASE_ITEMS = 250;

  // Indexes past the register list; writes there must be ignored
  localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [1:0] gesture;
    logic [1:0] region;
    logic [9:0] x;
    logic [9:0] y;
  } gesture_rec_t;

  typedef struct {
    logic         pen;
    logic [9:0]   x;
    logic [9:0]   y;
    logic [31:0]  t;
    bit           typed;
    gesture_rec_t want;
  } touch_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_W-1:0]          in_tdata;   // touch_x, touch_y, time_ms, zero fill
  logic                     in_tuser;   // pen_down
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_W-1:0]         out_tdata;  // tap_region, gesture_x, gesture_y, zero fill
  logic [1:0]               out_tuser;  // gesture
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  // Predictor copy of the registers and gesture state
  logic [9:0]  cfg_screen_w, cfg_hot_w, cfg_hot_h;
  logic [15:0] cfg_long_ms, cfg_tap_max, cfg_tap_gap;
  logic        pen_was_down, long_done;
  logic [31:0] press_t0, last_gesture_t;
  logic [9:0]  last_x, last_y;

  gesture_rec_t expected_gestures[$];
  touch_row_t   directed_rows[$];
  int           mismatch_count;
  int           samples_sent;
  bit           idling_on;
  logic [31:0]  clock_ms;

  touch_tap_long_press_classifier DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Gesture predictor: one sample in, one result out, state updated
  function automatic gesture_rec_t classify_touch(input logic pen, input logic [9:0] x,
                                                  input logic [9:0] y, input logic [31:0] t);
    gesture_rec_t r;
    int right_edge;
    r = '0;
    if (pen) begin
      last_x = x;
      last_y = y;
    end
    if (pen && !pen_was_down) begin
      press_t0 = t;
      long_done = 1'b0;
    end
    if (pen && !long_done && (t - press_t0) > {16'd0, cfg_long_ms}) begin
      long_done = 1'b1;
      last_gesture_t = t;
      r.gesture = GEST_LONG;
    end else if (!pen && pen_was_down && !long_done &&
                 (t - press_t0) < {16'd0, cfg_tap_max} &&
                 (t - last_gesture_t) > {16'd0, cfg_tap_gap}) begin
      last_gesture_t = t;
      r.gesture = GEST_TAP;
      // right edge is signed; a wide hotspot pushes it below zero
      right_edge = int'({22'd0, cfg_screen_w}) - int'({22'd0, cfg_hot_w});
      if (last_y < cfg_hot_h) begin
        if (last_x < cfg_hot_w)
          r.region = REGION_LEFT;
        else if (int'({22'd0, last_x}) > right_edge)
          r.region = REGION_RIGHT;
      end
    end
    pen_was_down = pen;
    if (r.gesture != GEST_NONE) begin
      r.x = last_x;
      r.y = last_y;
    end
    return r;
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // One sample transfer; expectation is pushed when the sample is taken
  task automatic send_sample(input logic pen, input logic [9:0] x, input logic [9:0] y,
                             input logic [31:0] t, input bit typed, input gesture_rec_t want);
    gesture_rec_t predicted;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= pen;
    in_tdata  <= {{(IN_W - 2 * COORD_W - 32){1'b0}}, t, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = classify_touch(pen, x, y, t);
    expected_gestures.push_back(typed ? want : predicted);
    samples_sent++;
  endtask

  task automatic add_row(input logic pen, input logic [9:0] x, input logic [9:0] y,
                         input logic [31:0] t, input bit typed, input logic [1:0] g,
                         input logic [1:0] r, input logic [9:0] gx, input logic [9:0] gy);
    touch_row_t row;
    row.pen = pen;
    row.x = x;
    row.y = y;
    row.t = t;
    row.typed = typed;
    row.want = '{g, r, gx, gy};
    directed_rows.push_back(row);
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_gestures.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_BITS-1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SCREEN_WIDTH:  cfg_screen_w = value[9:0];
      REG_HOT_WIDTH:     cfg_hot_w    = value[9:0];
      REG_HOT_HEIGHT:    cfg_hot_h    = value[9:0];
      REG_LONG_PRESS_MS: cfg_long_ms  = value;
      REG_TAP_MAX_MS:    cfg_tap_max  = value;
      REG_TAP_GAP_MS:    cfg_tap_gap  = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Every register gets a random, zero, one or full-scale value; 10-bit
  // registers carry junk in the upper data bits that must be dropped
  task automatic randomize_config();
    logic [15:0] value;
    for (int i = REG_SCREEN_WIDTH; i <= REG_TAP_GAP_MS; i++) begin
      case ($urandom_range(0, 5))
        0:       value = 16'd0;
        1:       value = 16'd1;
        2:       value = 16'hFFFF;
        default: value = 16'($urandom_range(1, (i <= REG_HOT_HEIGHT) ? 400 : 3000));
      endcase
      if (i <= REG_HOT_HEIGHT)
        value = {6'($urandom), value[9:0]};
      cfg_write(CFG_ADDR_BITS'(i), value);
    end
    cfg_write(REG_SPARE_LO, 16'($urandom));
    cfg_write(REG_SPARE_HI, 16'($urandom));
  endtask

  // Coordinates biased toward the hotspot edges
  function automatic logic [9:0] pick_x();
    int right_edge;
    right_edge = int'({22'd0, cfg_screen_w}) - int'({22'd0, cfg_hot_w});
    case ($urandom_range(0, 6))
      0:       return cfg_hot_w - 10'd1;
      1:       return cfg_hot_w;
      2:       return 10'(right_edge);
      3:       return 10'(right_edge + 1);
      4:       return 10'($urandom_range(0, 2 * cfg_hot_w + 2));
      default: return 10'($urandom);
    endcase
  endfunction

  function automatic logic [9:0] pick_y();
    case ($urandom_range(0, 4))
      0:       return cfg_hot_h - 10'd1;
      1:       return cfg_hot_h;
      2:       return 10'($urandom_range(0, cfg_hot_h));
      default: return 10'($urandom);
    endcase
  endfunction

  // One press: pen down, up to three held samples, release, with hold times and
  // gaps picked around the tap, long-press and gap thresholds
  task automatic press_sequence();
    logic [31:0] hold, lead, offset, pick;
    logic [9:0]  px, py;
    case ($urandom_range(0, 6))
      0:       hold = $urandom_range(0, cfg_tap_max);
      1:       hold = {16'd0, cfg_tap_max} - 32'd1;
      2:       hold = {16'd0, cfg_tap_max};
      3:       hold = {16'd0, cfg_tap_max} + 32'd1;
      4:       hold = {16'd0, cfg_long_ms};
      5:       hold = {16'd0, cfg_long_ms} + 32'd1;
      default: hold = $urandom_range(0, 2 * cfg_long_ms + 2);
    endcase
    // release-to-release spacing near the gap limit, or a free lead time
    case ($urandom_range(0, 3))
      0: lead = {16'd0, cfg_tap_gap} + 32'($urandom_range(0, 2)) - 32'd1;
      1: lead = $urandom_range(0, 100000);
      default: lead = $urandom_range(0, 2 * cfg_tap_gap + 2);
    endcase
    lead = (lead > hold) ? lead - hold : 32'd0;
    clock_ms = clock_ms + lead;
    px = pick_x();
    py = pick_y();
    send_sample(1'b1, px, py, clock_ms, 1'b0, '0);
    offset = 32'd0;
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 2))
        0:       pick = {16'd0, cfg_long_ms};
        1:       pick = {16'd0, cfg_long_ms} + 32'd1;
        default: pick = $urandom_range(offset, hold);
      endcase
      if (pick < offset || pick > hold)
        pick = $urandom_range(offset, hold);
      offset = pick;
      if ($urandom_range(0, 1) == 0) begin
        px = pick_x();
        py = pick_y();
      end
      send_sample(1'b1, px, py, clock_ms + offset, 1'b0, '0);
    end
    clock_ms = clock_ms + hold;
    send_sample(1'b0, 10'($urandom), 10'($urandom), clock_ms, 1'b0, '0);
  endtask

  // Mostly well-formed presses, the rest random or broken samples
  task automatic run_touch_traffic(input int count);
    int stop_at;
    stop_at = samples_sent + count;
    while (samples_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0: begin
          clock_ms = $urandom;
          send_sample(1'($urandom), 10'($urandom), 10'($urandom), clock_ms, 1'b0, '0);
        end
        1: begin
          clock_ms = clock_ms + $urandom_range(0, 2000);
          send_sample(1'($urandom), pick_x(), pick_y(), clock_ms, 1'b0, '0);
        end
        default: press_sequence();
      endcase
    end
  endtask

  // Receiver: ready with random stall bursts
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin : result_check
    gesture_rec_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[1:0], out_tdata[11:2], out_tdata[21:12]};
      if (expected_gestures.size() == 0) begin
        note_failure($sformatf("unexpected result gesture=%0d region=%0d x=%0d y=%0d",
                               got.gesture, got.region, got.x, got.y));
      end else begin
        want = expected_gestures.pop_front();
        if (got.gesture !== want.gesture || got.region !== want.region ||
            got.x !== want.x || got.y !== want.y || out_tdata[OUT_W-1:22] !== '0)
          note_failure($sformatf({"result mismatch: exp gesture=%0d region=%0d x=%0d y=%0d",
                                  " got gesture=%0d region=%0d x=%0d y=%0d fill=%0h"},
                                 want.gesture, want.region, want.x, want.y, got.gesture,
                                 got.region, got.x, got.y, out_tdata[OUT_W-1:22]));
      end
    end
  end

  // Hard limit on run time
  initial begin
    #2_000_000;
    $display("touch_tap_long_press_classifier test failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    idling_on = 1'b1;
    mismatch_count = 0;
    samples_sent = 0;
    cfg_screen_w = SCREEN_W_RST;
    cfg_hot_w = HOT_W_RST;
    cfg_hot_h = HOT_H_RST;
    cfg_long_ms = LONG_MS_RST;
    cfg_tap_max = TAP_MAX_RST;
    cfg_tap_gap = TAP_GAP_RST;
    pen_was_down = 1'b0;
    long_done = 1'b0;
    press_t0 = '0;
    last_gesture_t = '0;
    last_x = '0;
    last_y = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed samples at the reset register values
    add_row(1'b0, 10'd0, 10'd0, 32'd0, 1, GEST_NONE, REGION_OTHER, 10'd0, 10'd0);
    add_row(1'b1, 10'd10, 10'd10, 32'd1000, 1, GEST_NONE, REGION_OTHER, 10'd0, 10'd0);
    add_row(1'b0, 10'd0, 10'd0, 32'd1100, 1, GEST_TAP, REGION_LEFT, 10'd10, 10'd10);
    // release too soon after the previous tap
    add_row(1'b1, 10'd1023, 10'd0, 32'd1200, 1, GEST_NONE, REGION_OTHER, 10'd0, 10'd0);
    add_row(1'b0, 10'd0, 10'd0, 32'd1300, 1, GEST_NONE, REGION_OTHER, 10'd0, 10'd0);
    // coordinates on a pen-up sample are ignored
    add_row(1'b1, 10'd1023, 10'd0, 32'd2000, 1, GEST_NONE, REGION_OTHER, 10'd0, 10'd0);
    add_row(1'b0, 10'd1023, 10'd1023, 32'd2100, 1, GEST_TAP, REGION_RIGHT, 10'd1023, 10'd0);
    // long press: exactly at the limit nothing, one past it fires once
    add_row(1'b1, 10'd0, 10'd1023, 32'd3000, 1, GEST_NONE, REGION_OTHER, 10'd0, 10'd0);
    add_row(1'b1, 10'd0, 10'd1023, 32'd3850, 0, GEST_NONE, REGION_OTHER, 10'd0, 10'd0);
    add_row(1'b1, 10'd0, 10'd1023, 32'd3851, 1, GEST_LONG, REGION_OTHER, 10'd0, 10'd1023);
    add_row(1'b1, 10'd0, 10'd1023, 32'd4000, 0, GEST_NONE, REGION_OTHER, 10'd0, 10'd0);
    add_row(1'b0, 10'd0, 10'd0, 32'd4010, 1, GEST_NONE, REGION_OTHER, 10'd0, 10'd0);
    // tap just under the max duration, then exactly at it
    add_row(1'b1, 10'd100, 10'd20, 32'd5000, 1, GEST_NONE, REGION_OTHER, 10'd0, 10'd0);
    add_row(1'b0, 10'd0, 10'd0, 32'd5599, 1, GEST_TAP, REGION_OTHER, 10'd100, 10'd20);
    add_row(1'b1, 10'd5, 10'd5, 32'd6000, 1, GEST_NONE, REGION_OTHER, 10'd0, 10'd0);
    add_row(1'b0, 10'd0, 10'd0, 32'd6600, 1, GEST_NONE, REGION_OTHER, 10'd0, 10'd0);
    // press across the timestamp wrap, inner hotspot corner
    add_row(1'b1, 10'd47, 10'd52, 32'hFFFF_FF00, 1, GEST_NONE, REGION_OTHER, 10'd0, 10'd0);
    add_row(1'b0, 10'd0, 10'd0, 32'h0000_0010, 1, GEST_TAP, REGION_LEFT, 10'd47, 10'd52);
    // first x past the right edge, then just outside both hotspots
    add_row(1'b1, 10'd193, 10'd52, 32'd100000, 1, GEST_NONE, REGION_OTHER, 10'd0, 10'd0);
    add_row(1'b0, 10'd0, 10'd0, 32'd100001, 1, GEST_TAP, REGION_RIGHT, 10'd193, 10'd52);
    add_row(1'b1, 10'd48, 10'd53, 32'd101000, 1, GEST_NONE, REGION_OTHER, 10'd0, 10'd0);
    add_row(1'b0, 10'd0, 10'd0, 32'd101001, 1, GEST_TAP, REGION_OTHER, 10'd48, 10'd53);
    // zero-length press at the top of the time range
    add_row(1'b1, 10'd0, 10'd0, 32'hFFFF_FFFF, 1, GEST_NONE, REGION_OTHER, 10'd0, 10'd0);
    add_row(1'b0, 10'd0, 10'd0, 32'hFFFF_FFFF, 1, GEST_TAP, REGION_LEFT, 10'd0, 10'd0);
    foreach (directed_rows[i])
      send_sample(directed_rows[i].pen, directed_rows[i].x, directed_rows[i].y,
                  directed_rows[i].t, directed_rows[i].typed, directed_rows[i].want);

    // Random traffic at the reset register values
    clock_ms = $urandom;
    run_touch_traffic(PHASE_ITEMS);

    wait_drained();
    randomize_config();
    run_touch_traffic(PHASE_ITEMS);

    // Every register at full scale
    wait_drained();
    cfg_write(REG_SCREEN_WIDTH, 16'hFFFF);
    cfg_write(REG_HOT_WIDTH, 16'h03FF);
    cfg_write(REG_HOT_HEIGHT, 16'hFFFF);
    cfg_write(REG_LONG_PRESS_MS, 16'hFFFF);
    cfg_write(REG_TAP_MAX_MS, 16'hFFFF);
    cfg_write(REG_TAP_GAP_MS, 16'hFFFF);
    cfg_write(REG_SPARE_LO, 16'h0000);
    run_touch_traffic(PHASE_ITEMS);

    // Every register at zero; upper data bits must be dropped
    wait_drained();
    cfg_write(REG_SCREEN_WIDTH, 16'hFC00);
    cfg_write(REG_HOT_WIDTH, 16'hFC00);
    cfg_write(REG_HOT_HEIGHT, 16'hFC00);
    cfg_write(REG_LONG_PRESS_MS, 16'h0000);
    cfg_write(REG_TAP_MAX_MS, 16'h0000);
    cfg_write(REG_TAP_GAP_MS, 16'h0000);
    run_touch_traffic(PHASE_ITEMS);

    // Hotspot wider than the screen: right edge below zero
    wait_drained();
    randomize_config();
    cfg_write(REG_SCREEN_WIDTH, 16'($urandom_range(1, 500)));
    cfg_write(REG_HOT_WIDTH, 16'($urandom_range(cfg_screen_w + 1, 1023)));
    cfg_write(REG_HOT_HEIGHT, 16'($urandom_range(20, 600)));
    cfg_write(REG_TAP_MAX_MS, 16'($urandom_range(200, 3000)));
    run_touch_traffic(PHASE_ITEMS);

    wait_drained();
    randomize_config();
    run_touch_traffic(PHASE_ITEMS);

    // Last stretch at full rate
    wait_drained();
    randomize_config();
    idling_on = 1'b0;
    run_touch_traffic(PHASE_ITEMS);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("touch_tap_long_press_classifier test passed");
    else
      $display("touch_tap_long_press_classifier test failed");
    $finish;
  end

endmodule
